// ----- src/stable_insertion_sorter_macros.svh -----
// ---------------------------------------------------------------------------
// Stable insertion sorter assertion macros
// Concurrent assertion shorthands used by the sorter checker.
// ---------------------------------------------------------------------------
`ifndef STABLE_INSERTION_SORTER_MACROS_SVH
`define STABLE_INSERTION_SORTER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SIS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a consequent holds in the cycle after an antecedent.
`define SIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sis_pkg.sv -----
// ---------------------------------------------------------------------------
// Stable insertion sorter package
// Sizes, item layout and the command/status groups between control and data.
// ---------------------------------------------------------------------------
package sis_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int TDATA_W   = KEY_W + PAY_W;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic insert;     // insert the input word, or flag overflow when full
    logic shift_out;  // drop the head cell and advance the rest by one
  } sis_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic one_left;   // the head is the last stored item
  } sis_status_t;

endpackage

// ----- src/sis_ctrl.sv -----
// ---------------------------------------------------------------------------
// Stable insertion sorter controller
// Collect phase takes input words, drain phase hands out the sorted set.
// ---------------------------------------------------------------------------
module sis_ctrl
  import sis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_last_i,
  input  logic        m_ready_i,
  input  sis_status_t status_i,
  output logic        s_ready_o,
  output logic        m_valid_o,
  output sis_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   s_fire;
  logic   m_fire;

  assign s_ready_o = (state_q == ST_COLLECT);
  assign m_valid_o = (state_q == ST_DRAIN);
  assign s_fire    = s_valid_i & s_ready_o;
  assign m_fire    = m_valid_o & m_ready_i;

  assign cmd_o.insert    = s_fire;
  assign cmd_o.shift_out = m_fire;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: begin
        if (s_fire && s_last_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (m_fire && status_i.one_left) state_d = ST_COLLECT;
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/sis_datapath.sv -----
// ---------------------------------------------------------------------------
// Stable insertion sorter datapath
// Row of sorted cells with parallel compare-and-shift insert and head drain.
// ---------------------------------------------------------------------------
module sis_datapath
  import sis_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sis_cmd_t          cmd_i,
  input  logic [KEY_W-1:0]  in_key_i,
  input  logic [PAY_W-1:0]  in_pay_i,
  output logic [KEY_W-1:0]  head_key_o,
  output logic [PAY_W-1:0]  head_pay_o,
  output logic              overflow_o,
  output sis_status_t       status_o
);

  logic [KEY_W-1:0] key_q [MAX_ITEMS];
  logic [KEY_W-1:0] key_d [MAX_ITEMS];
  logic [PAY_W-1:0] pay_q [MAX_ITEMS];
  logic [PAY_W-1:0] pay_d [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] gt;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             full;

  assign full              = (count_q == CNT_W'(MAX_ITEMS));
  assign status_o.one_left = (count_q == CNT_W'(1));
  assign head_key_o        = key_q[0];
  assign head_pay_o        = pay_q[0];
  assign overflow_o        = ovf_q;

  // Occupied cells whose key is strictly larger move up; equal keys stay ahead
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      gt[i] = (CNT_W'(i) < count_q) && (key_q[i] > in_key_i);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      key_d[i] = key_q[i];
      pay_d[i] = pay_q[i];
    end
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.insert) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
        if (gt[0] || (count_q == '0)) begin
          key_d[0] = in_key_i;
          pay_d[0] = in_pay_i;
        end
        for (int i = 1; i < MAX_ITEMS; i++) begin
          if (gt[i-1]) begin
            key_d[i] = key_q[i-1];
            pay_d[i] = pay_q[i-1];
          end else if (gt[i] || (CNT_W'(i) == count_q)) begin
            key_d[i] = in_key_i;
            pay_d[i] = in_pay_i;
          end
        end
      end
    end else if (cmd_i.shift_out) begin
      for (int i = 0; i < MAX_ITEMS - 1; i++) begin
        key_d[i] = key_q[i+1];
        pay_d[i] = pay_q[i+1];
      end
      count_d = count_q - CNT_W'(1);
      if (count_q == CNT_W'(1)) ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      key_q[i] <= key_d[i];
      pay_q[i] <= pay_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ----- src/stable_insertion_sorter.sv -----
// ---------------------------------------------------------------------------
// Stable insertion sorter
// Collects a set of key/payload words and emits them in stable ascending order.
// ---------------------------------------------------------------------------
// Usage:
//   Send a set of words on the slave channel, tlast on the final one. Each
//   word is placed into a row of MAX_ITEMS cells in parallel: cells with a
//   larger key move up by one, so equal keys keep their arrival order.
//   Input throughput is one word per cycle while collecting.
//   Once the tlast word is taken, s_axis_tready_o drops and the next cycle
//   the master channel shows the smallest key. Each accepted output word
//   shifts the row down by one, so the set drains at one word per cycle
//   while the receiver is ready. After the final word (tlast) is taken,
//   the block is ready for a new set on the following cycle. Words
//   arriving with the row full are dropped; tuser is then high on every
//   output word of that set. A dropped tlast word still starts output.
//   When the receiver stalls, the head word holds and nothing advances.
//   Reset empties the row and clears the overflow flag; cell contents are
//   left as they are and never read before being written.
// ---------------------------------------------------------------------------
module stable_insertion_sorter
  import sis_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,  // [31:0] sort_key, [63:32] payload
  input  logic               s_axis_tlast_i,  // last_item
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,  // [31:0] sorted_key, [63:32] sorted_payload
  output logic               m_axis_tlast_o,  // final_result
  output logic               m_axis_tuser_o   // overflowed
);

  sis_cmd_t         cmd;
  sis_status_t      status;
  logic [KEY_W-1:0] head_key;
  logic [PAY_W-1:0] head_pay;
  logic             overflow;

  // Sequence the collect and drain phases
  sis_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .cmd_o     (cmd)
  );

  // Hold the sorted row; insert on input words, advance on output words
  sis_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_key_i   (s_axis_tdata_i[KEY_W-1:0]),
    .in_pay_i   (s_axis_tdata_i[TDATA_W-1:KEY_W]),
    .head_key_o (head_key),
    .head_pay_o (head_pay),
    .overflow_o (overflow),
    .status_o   (status)
  );

  // The head cell is a register, so the output word comes straight from it
  assign m_axis_tdata_o = {head_pay, head_key};
  assign m_axis_tlast_o = status.one_left;
  assign m_axis_tuser_o = overflow;

endmodule

// ----- src/sis_checker.sv -----
// ---------------------------------------------------------------------------
// Stable insertion sorter checker
// Port-level checks on phase sequencing, output order and stall behavior.
// ---------------------------------------------------------------------------
`include "stable_insertion_sorter_macros.svh"

module sis_checker
  import sis_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               s_axis_tlast_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [TDATA_W-1:0] m_axis_tdata_o,
  input logic               m_axis_tlast_o,
  input logic               m_axis_tuser_o
);

  logic s_fire;
  logic m_fire;
  logic s_last_fire;
  logic m_mid_fire;
  logic drain_only;
  logic collect_only;
  logic m_stall;

  assign s_fire       = s_axis_tvalid_i & s_axis_tready_o;
  assign m_fire       = m_axis_tvalid_o & m_axis_tready_i;
  assign s_last_fire  = s_fire & s_axis_tlast_i;
  assign m_mid_fire   = m_fire & ~m_axis_tlast_o;
  assign drain_only   = m_axis_tvalid_o & ~s_axis_tready_o;
  assign collect_only = s_axis_tready_o & ~m_axis_tvalid_o;
  assign m_stall      = m_axis_tvalid_o & ~m_axis_tready_i;

  // A tlast input word starts the drain on the next cycle
  `SIS_ASSERT_NEXT(a_last_starts_drain, clk_i, rst_ni, s_last_fire, drain_only,
                   "drain did not start after input tlast")

  // Keys leave in ascending order within a set and the overflow flag holds
  `SIS_ASSERT_NEXT(a_keys_ascend, clk_i, rst_ni, m_mid_fire,
                   m_axis_tvalid_o && $stable(m_axis_tuser_o) &&
                   (m_axis_tdata_o[KEY_W-1:0] >= $past(m_axis_tdata_o[KEY_W-1:0])),
                   "output keys out of order or overflow flag changed")

  // The final output word returns the block to collecting
  `SIS_ASSERT_NEXT(a_end_resumes_collect, clk_i, rst_ni, m_fire && m_axis_tlast_o,
                   collect_only, "collect phase did not resume")

  // A stalled output word holds
  `SIS_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, m_stall,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o) &&
                   $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o),
                   "stalled output word changed")

endmodule

bind stable_insertion_sorter sis_checker u_sis_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
